// ----- rtl/core/swia_pkg.sv -----
// swia_pkg: shared types and constants for the signed wide integer ALU.
// Holds the beat structs, the mode codes and the queue entry type.
// No dependencies.
package swia_pkg;

    localparam int WordBits  = 128;
    localparam int HalfBits  = 64;
    localparam int ShiftBits = 7;
    localparam int CountBits = 7;
    localparam int LimbBits  = 32;
    localparam int MulSteps  = 10;

    typedef enum logic [3:0] {
        MODE_ADD = 4'd0,
        MODE_SUB = 4'd1,
        MODE_MUL = 4'd2,
        MODE_DIV = 4'd3,
        MODE_AND = 4'd4,
        MODE_OR  = 4'd5,
        MODE_XOR = 4'd6,
        MODE_NOT = 4'd7,
        MODE_SHL = 4'd8,
        MODE_SAR = 4'd9,
        MODE_ROL = 4'd10,
        MODE_ROR = 4'd11,
        MODE_CMP = 4'd12
    } mode_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] a_high;
        logic [63:0] a_low;
        logic [63:0] b_high;
        logic [63:0] b_low;
        logic [6:0]  shift_amount;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        less_flag;
        logic        greater_flag;
        logic        equal_flag;
        logic        divide_by_zero;
    } out_beat_t;

    // Operation class chosen by the front end
    typedef enum logic [2:0] {
        CLS_DIRECT = 3'b001,
        CLS_MUL    = 3'b010,
        CLS_DIV    = 3'b100
    } op_class_t;

    // Entry handed from front to back
    typedef struct packed {
        op_class_t             cls;
        logic [WordBits-1:0]   a;
        logic [WordBits-1:0]   b;
        logic [WordBits-1:0]   direct;
        logic                  less_flag;
        logic                  greater_flag;
        logic                  equal_flag;
        logic                  divide_by_zero;
    } work_t;

endpackage

// ----- rtl/core/swia_front.sv -----
// swia_front: accepts input beats, computes the direct results and flags,
// and classifies each beat for the back end. Depends on swia_pkg.
module swia_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  swia_pkg::in_beat_t in_data,
    output logic               q_valid,
    input  logic               q_stall,
    output swia_pkg::work_t    q_data
);

    logic                          valid_reg;
    swia_pkg::work_t               data_reg;
    swia_pkg::work_t               work;
    logic [swia_pkg::WordBits-1:0] a;
    logic [swia_pkg::WordBits-1:0] b;
    logic [swia_pkg::WordBits-1:0] sa;
    logic [swia_pkg::WordBits-1:0] sb;
    logic [swia_pkg::WordBits-1:0] dbl_src;
    logic [2*swia_pkg::WordBits-1:0] dbl;
    logic [swia_pkg::ShiftBits-1:0] rot;

    assign a  = {in_data.a_high, in_data.a_low};
    assign b  = {in_data.b_high, in_data.b_low};
    assign sa = a ^ {1'b1, {(swia_pkg::WordBits-1){1'b0}}};
    assign sb = b ^ {1'b1, {(swia_pkg::WordBits-1){1'b0}}};

    // Rotates: shift a doubled word; ror by n is rol by -n
    assign rot     = (in_data.mode == swia_pkg::MODE_ROR) ?
                     (~in_data.shift_amount + 7'd1) : in_data.shift_amount;
    assign dbl_src = a;
    assign dbl     = {dbl_src, dbl_src} << rot;

    // Classify and compute the cheap modes
    always_comb
    begin
        work              = '0;
        work.cls          = swia_pkg::CLS_DIRECT;
        work.a            = a;
        work.b            = b;
        work.less_flag    = sa < sb;
        work.greater_flag = sb < sa;
        work.equal_flag   = a == b;
        case (in_data.mode)
            swia_pkg::MODE_ADD: work.direct = a + b;
            swia_pkg::MODE_SUB: work.direct = a - b;
            swia_pkg::MODE_MUL: work.cls = swia_pkg::CLS_MUL;
            swia_pkg::MODE_DIV:
            begin
                if (b == '0)
                    work.divide_by_zero = 1'b1;
                else
                    work.cls = swia_pkg::CLS_DIV;
            end
            swia_pkg::MODE_AND: work.direct = a & b;
            swia_pkg::MODE_OR:  work.direct = a | b;
            swia_pkg::MODE_XOR: work.direct = a ^ b;
            swia_pkg::MODE_NOT: work.direct = ~a;
            swia_pkg::MODE_SHL:
            begin
                work.direct = a << in_data.shift_amount;
                work.direct[swia_pkg::WordBits-1] = a[swia_pkg::WordBits-1];
            end
            swia_pkg::MODE_SAR: work.direct = $signed(a) >>> in_data.shift_amount;
            swia_pkg::MODE_ROL, swia_pkg::MODE_ROR:
                work.direct = dbl[2*swia_pkg::WordBits-1 -: swia_pkg::WordBits];
            default: work.direct = '0;
        endcase
    end

    assign in_stall = valid_reg && q_stall;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    // Output register toward the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            data_reg <= work;
    end

endmodule

// ----- rtl/core/swia_queue.sv -----
// swia_queue: two-entry queue between front and back ends.
// Depends on swia_pkg.
module swia_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  swia_pkg::work_t wr_data,
    output logic            rd_valid,
    input  logic            rd_stall,
    output swia_pkg::work_t rd_data
);

    swia_pkg::work_t mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign wr_stall = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/core/swia_back.sv -----
// swia_back: executes queued work: passes direct results, runs the
// multiply as ten 32x32 partial products, and the divide bit-serially.
// Depends on swia_pkg.
module swia_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_stall,
    input  swia_pkg::work_t     q_data,
    output logic                out_valid,
    input  logic                out_stall,
    output swia_pkg::out_beat_t out_data
);

    localparam int W = swia_pkg::WordBits;
    localparam int H = swia_pkg::HalfBits;
    localparam int L = swia_pkg::LimbBits;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [swia_pkg::CountBits-1:0] cnt_reg;
    logic [W-1:0]          x_reg;
    logic [W-1:0]          y_reg;
    logic [W-1:0]          acc_reg;
    logic [W-1:0]          rem_reg;
    logic                  neg_reg;
    logic                  lt_reg, gt_reg, eq_reg, dz_reg;
    logic                  div_beat_reg;
    logic                  out_valid_reg;
    swia_pkg::out_beat_t   out_reg;

    logic [1:0]            mi, mj;
    logic [1:0]            off;
    logic [L-1:0]          mx, my;
    logic [2*L-1:0]        prod;
    logic [W-1:0]          prod_sh;
    logic [W:0]            rem_sh;
    logic [W:0]            rem_diff;
    logic [W-1:0]          fin;
    logic                  take;
    logic                  out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_stall   = state_reg != ST_IDLE;
    assign take      = q_valid && state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // One 32x32 multiply per step; only limb pairs that reach the low 128 bits
    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0:    {mi, mj} = {2'd0, 2'd0};
            4'd1:    {mi, mj} = {2'd0, 2'd1};
            4'd2:    {mi, mj} = {2'd1, 2'd0};
            4'd3:    {mi, mj} = {2'd0, 2'd2};
            4'd4:    {mi, mj} = {2'd1, 2'd1};
            4'd5:    {mi, mj} = {2'd2, 2'd0};
            4'd6:    {mi, mj} = {2'd0, 2'd3};
            4'd7:    {mi, mj} = {2'd1, 2'd2};
            4'd8:    {mi, mj} = {2'd2, 2'd1};
            default: {mi, mj} = {2'd3, 2'd0};
        endcase
    end
    assign mx      = x_reg[mi*L +: L];
    assign my      = y_reg[mj*L +: L];
    assign prod    = mx * my;
    assign off     = mi + mj;
    assign prod_sh = {{(W-2*L){1'b0}}, prod} << {off, 5'd0};

    // Restoring divide step
    assign rem_sh   = {rem_reg, x_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, y_reg};
    assign fin      = neg_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    case (q_data.cls)
                        swia_pkg::CLS_MUL: state_next = ST_MUL;
                        swia_pkg::CLS_DIV: state_next = ST_DIV;
                        default:           state_next = ST_DONE;
                    endcase
                end
            ST_MUL:  if (cnt_reg == 7'(swia_pkg::MulSteps-1)) state_next = ST_DONE;
            ST_DIV:  if (cnt_reg == 7'(W-1)) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL || state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 7'd1;
            else
                cnt_reg <= '0;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lt_reg       <= q_data.less_flag;
            gt_reg       <= q_data.greater_flag;
            eq_reg       <= q_data.equal_flag;
            dz_reg       <= q_data.divide_by_zero;
            neg_reg      <= q_data.a[W-1] ^ q_data.b[W-1];
            div_beat_reg <= q_data.cls == swia_pkg::CLS_DIV;
            rem_reg      <= '0;
            if (q_data.cls == swia_pkg::CLS_DIV)
            begin
                x_reg   <= q_data.a[W-1] ? -q_data.a : q_data.a;
                y_reg   <= q_data.b[W-1] ? -q_data.b : q_data.b;
                acc_reg <= '0;
            end
            else
            begin
                // direct is zero for multiply beats: the accumulator starts clear
                x_reg   <= q_data.a;
                y_reg   <= q_data.b;
                acc_reg <= q_data.direct;
            end
        end
        else if (state_reg == ST_MUL)
        begin
            acc_reg <= acc_reg + prod_sh;
        end
        else if (state_reg == ST_DIV)
        begin
            x_reg <= {x_reg[W-2:0], 1'b0};
            if (!rem_diff[W])
            begin
                rem_reg <= rem_diff[W-1:0];
                acc_reg <= {acc_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[W-1:0];
                acc_reg <= {acc_reg[W-2:0], 1'b0};
            end
        end
    end

    // Result register; division sign is applied only for divide beats
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.result_high    <= (div_beat_reg ? fin[W-1:H] : acc_reg[W-1:H]);
            out_reg.result_low     <= (div_beat_reg ? fin[H-1:0] : acc_reg[H-1:0]);
            out_reg.less_flag      <= lt_reg;
            out_reg.greater_flag   <= gt_reg;
            out_reg.equal_flag     <= eq_reg;
            out_reg.divide_by_zero <= dz_reg;
        end
    end

endmodule

// ----- rtl/core/signed_wide_integer_alu.sv -----
// signed_wide_integer_alu: top level of the 128-bit signed ALU.
// Instantiates swia_front, swia_queue and swia_back; uses swia_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per beat
//   (mode, operands A and B as high/low halves, shift amount). Output
//   channel out_valid/out_stall/out_data returns one result beat per input:
//   128-bit result plus signed less/greater/equal flags and divide_by_zero.
//   Results leave in input order.
// Operation:
//   Add, logic, compare, shift and rotate beats are computed in the front
//   end and only pass through the back end. Multiply adds the back end's
//   multiply state: one 32x32 multiplier works through the ten partial
//   products that reach the low 128 bits. Divide adds its divide state: one
//   restoring subtract per quotient bit. The back end handles one beat at a
//   time; the front end and a two-entry queue keep accepting beats meanwhile.
// Reset:
//   rst_n clears all valid state; no beat is pending after reset.
// Stall:
//   A stalled output holds its beat; the back end waits, the queue fills,
//   and then in_stall rises.
module signed_wide_integer_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swia_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output swia_pkg::out_beat_t out_data
);

    logic            f_valid, f_stall;
    swia_pkg::work_t f_data;
    logic            b_valid, b_stall;
    swia_pkg::work_t b_data;

    swia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (f_valid),
        .q_stall  (f_stall),
        .q_data   (f_data)
    );

    swia_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_stall (b_stall),
        .rd_data  (b_data)
    );

    swia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_stall   (b_stall),
        .q_data    (b_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/swia_checker.sv -----
// swia_checker: port-level checks for signed_wide_integer_alu.
// Bound to the top level below; uses swia_pkg.
module swia_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  swia_pkg::out_beat_t out_data
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // Less and greater never both set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.less_flag && out_data.greater_flag))
        else $error("less and greater both set");

    // Equal excludes less and greater
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.equal_flag |->
            !out_data.less_flag && !out_data.greater_flag)
        else $error("equal with ordering flag");

    // Divide by zero yields a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_by_zero |->
            out_data.result_high == '0 && out_data.result_low == '0)
        else $error("divide by zero with nonzero result");

    // No result right after reset without an input beat
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat out of reset");

endmodule

bind signed_wide_integer_alu swia_checker u_swia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- dv/tb.sv -----
// tb: self-checking testbench for signed_wide_integer_alu.
// Predicts every result beat from the input beat; depends on swia_pkg and the RTL.
module tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    swia_pkg::in_beat_t  in_data;
    logic                out_valid;
    logic                out_stall;
    swia_pkg::out_beat_t out_data;

    swia_pkg::out_beat_t expected_q[$];
    int                  mismatch_count;
    int                  cycle_count;
    bit                  quiet_tail;

    localparam logic [127:0] MostNeg = {1'b1, 127'd0};
    localparam logic [127:0] AllOnes = '1;
    localparam int           CycleLimit = 2000000;

    signed_wide_integer_alu dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Truncating signed divide via magnitudes
    function automatic logic [127:0] signed_quotient(logic [127:0] num, logic [127:0] den);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        un = num[127] ? -num : num;
        ud = den[127] ? -den : den;
        q = un / ud;
        return (num[127] ^ den[127]) ? -q : q;
    endfunction

    // Expected result beat for one input beat
    function automatic swia_pkg::out_beat_t alu_predict(swia_pkg::in_beat_t beat);
        swia_pkg::out_beat_t res;
        logic [127:0]        a;
        logic [127:0]        b;
        logic [127:0]        r;
        logic [255:0]        dbl;
        int                  n;
        a = {beat.a_high, beat.a_low};
        b = {beat.b_high, beat.b_low};
        n = int'(beat.shift_amount);
        r = '0;
        res.divide_by_zero = 1'b0;
        case (beat.mode)
            swia_pkg::MODE_ADD: r = a + b;
            swia_pkg::MODE_SUB: r = a - b;
            swia_pkg::MODE_MUL: r = a * b;
            swia_pkg::MODE_DIV:
            begin
                if (b == 0)
                    res.divide_by_zero = 1'b1;
                else
                    r = signed_quotient(a, b);
            end
            swia_pkg::MODE_AND: r = a & b;
            swia_pkg::MODE_OR:  r = a | b;
            swia_pkg::MODE_XOR: r = a ^ b;
            swia_pkg::MODE_NOT: r = ~a;
            swia_pkg::MODE_SHL:
            begin
                r = a << n;
                r[127] = a[127];
            end
            swia_pkg::MODE_SAR: r = $signed(a) >>> n;
            swia_pkg::MODE_ROL:
            begin
                dbl = {a, a} << n;
                r = dbl[255:128];
            end
            swia_pkg::MODE_ROR:
            begin
                dbl = {a, a} >> n;
                r = dbl[127:0];
            end
            default: r = '0;
        endcase
        res.result_high  = r[127:64];
        res.result_low   = r[63:0];
        res.less_flag    = $signed(a) < $signed(b);
        res.greater_flag = $signed(a) > $signed(b);
        res.equal_flag   = a == b;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    // Send one beat, with an optional idle burst first
    task automatic send_beat(logic [3:0] mode, logic [127:0] a, logic [127:0] b,
                             logic [6:0] sh);
        swia_pkg::in_beat_t beat;
        beat.mode = mode;
        {beat.a_high, beat.a_low} = a;
        {beat.b_high, beat.b_low} = b;
        beat.shift_amount = sh;
        if (!quiet_tail && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q = {expected_q, alu_predict(beat)};
    endtask

    // Output side: random stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(5, 1)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        swia_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", out_data.result_low, 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (out_data.result_high !== want.result_high)
                    report_mismatch("result_high", out_data.result_high, want.result_high);
                if (out_data.result_low !== want.result_low)
                    report_mismatch("result_low", out_data.result_low, want.result_low);
                if (out_data.less_flag !== want.less_flag)
                    report_mismatch("less_flag", 64'(out_data.less_flag),
                                    64'(want.less_flag));
                if (out_data.greater_flag !== want.greater_flag)
                    report_mismatch("greater_flag", 64'(out_data.greater_flag),
                                    64'(want.greater_flag));
                if (out_data.equal_flag !== want.equal_flag)
                    report_mismatch("equal_flag", 64'(out_data.equal_flag),
                                    64'(want.equal_flag));
                if (out_data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", 64'(out_data.divide_by_zero),
                                    64'(want.divide_by_zero));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [127:0] rand_word();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(7))
            0: w = w >> $urandom_range(127);
            1: w = -(w >> $urandom_range(127));
            2: w = {128{w[0]}};
            3: w = w[0] ? MostNeg : (MostNeg - 1);
            default: ;
        endcase
        return w;
    endfunction

    // Directed: operand extremes and special cases
    task automatic test_directed();
        send_beat(swia_pkg::MODE_ADD, AllOnes, 128'd1, 7'd0);
        send_beat(swia_pkg::MODE_SUB, MostNeg, 128'd1, 7'd0);
        send_beat(swia_pkg::MODE_MUL, MostNeg, AllOnes, 7'd0);
        send_beat(swia_pkg::MODE_MUL, AllOnes, AllOnes, 7'd0);
        send_beat(swia_pkg::MODE_DIV, 128'd100, 128'd0, 7'd0);
        send_beat(swia_pkg::MODE_DIV, MostNeg, AllOnes, 7'd0);
        send_beat(swia_pkg::MODE_DIV, -128'sd7, 128'd2, 7'd0);
        send_beat(swia_pkg::MODE_DIV, 128'd7, -128'sd2, 7'd0);
        send_beat(swia_pkg::MODE_DIV, MostNeg, MostNeg, 7'd0);
        send_beat(swia_pkg::MODE_AND, AllOnes, MostNeg - 1, 7'd0);
        send_beat(swia_pkg::MODE_OR, 128'd0, MostNeg, 7'd0);
        send_beat(swia_pkg::MODE_XOR, AllOnes, AllOnes, 7'd0);
        send_beat(swia_pkg::MODE_NOT, 128'd0, AllOnes, 7'd0);
        send_beat(swia_pkg::MODE_SHL, MostNeg | 128'd3, 128'd0, 7'd1);
        send_beat(swia_pkg::MODE_SHL, 128'd1, 128'd0, 7'd127);
        send_beat(swia_pkg::MODE_SAR, MostNeg, 128'd0, 7'd127);
        send_beat(swia_pkg::MODE_SAR, AllOnes, 128'd0, 7'd0);
        send_beat(swia_pkg::MODE_ROL, MostNeg | 128'd1, 128'd0, 7'd127);
        send_beat(swia_pkg::MODE_ROR, 128'd1, 128'd0, 7'd0);
        send_beat(swia_pkg::MODE_ROR, 128'd1, 128'd0, 7'd1);
        send_beat(swia_pkg::MODE_CMP, MostNeg, MostNeg - 1, 7'd0);
        send_beat(swia_pkg::MODE_CMP, AllOnes, AllOnes, 7'd0);
        // Undefined modes: zero result, flags still computed
        send_beat(4'd13, 128'd5, 128'd0, 7'd3);
        send_beat(4'd15, 128'd0, 128'd5, 7'd127);
    endtask

    // Random beats over every mode
    task automatic test_random(int count);
        logic [127:0] a;
        logic [127:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = rand_word();
            b = ($urandom_range(9) == 0) ? a : rand_word();
            if ($urandom_range(19) == 0)
                b = '0;
            send_beat(4'($urandom_range(15)), a, b, 7'($urandom_range(127)));
        end
    endtask

    // Sender holds off until all results are back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_tail     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_random(900);
        drain();
        quiet_tail = 1'b1;
        test_random(200);
        drain();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
